[rtl/core/ps2sc_pkg.sv]
// Shared types, constants and valid-code lookups for the PS/2 set 2 decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package ps2sc_pkg;

    // Prefix and pause-sequence bytes
    localparam logic [7:0] BYTE_EXT     = 8'hE0;
    localparam logic [7:0] BYTE_PAUSE   = 8'hE1;
    localparam logic [7:0] BYTE_RELEASE = 8'hF0;
    localparam logic [7:0] BYTE_PAUSE_A = 8'h14;
    localparam logic [7:0] BYTE_PAUSE_B = 8'h77;

    // Reported event kinds
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_PAUSE   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    localparam int PAUSE_STEP_W = 3;
    localparam logic [PAUSE_STEP_W-1:0] PAUSE_LAST = 3'd7;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int MAIN_GROUPS = 17;
    localparam int EXT_GROUPS  = 16;

    // Bit i of entry g set: code 8*g+i is a valid key
    localparam logic [7:0] MAIN_MAP [MAIN_GROUPS] = '{
        8'hFA, 8'h7E, 8'h76, 8'h7C, 8'h7E, 8'h7E, 8'h7E, 8'h7C,
        8'h7E, 8'h7E, 8'h34, 8'h2F, 8'h40, 8'h1A, 8'hFF, 8'h7F,
        8'h08
    };

    localparam logic [7:0] EXT_MAP [EXT_GROUPS] = '{
        8'h00, 8'h00, 8'h33, 8'h81, 8'h8B, 8'h89, 8'h95, 8'h8D,
        8'h01, 8'h25, 8'h01, 8'h44, 8'h00, 8'h1A, 8'h37, 8'h34
    };

    // Expected byte at pause steps 1 to 6; entry 0 is never used
    localparam logic [7:0] PAUSE_EXPECT [7] = '{
        8'h00, BYTE_PAUSE_A, BYTE_PAUSE_B, BYTE_PAUSE,
        BYTE_RELEASE, BYTE_PAUSE_A, BYTE_RELEASE
    };

    // Work handed from front to back
    typedef enum logic [1:0] {
        OP_KEY_MAIN,
        OP_KEY_EXT,
        OP_PAUSE,
        OP_UNKNOWN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] code;
    } job_t;

    function automatic logic main_has(input logic [7:0] code);
        logic [7:0] row;
        begin
            row = 8'h00;
            if (code[7:3] < 5'(MAIN_GROUPS))
            begin
                row = MAIN_MAP[code[7:3]];
            end
            main_has = row[code[2:0]];
        end
    endfunction

    function automatic logic ext_has(input logic [7:0] code);
        logic [7:0] row;
        begin
            row = EXT_MAP[code[6:3]];
            ext_has = !code[7] && row[code[2:0]];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/ps2sc_front.sv]
// Front end: tracks the pause sequence and the release and extend prefixes,
// and turns each byte into an optional job. Depends on ps2sc_pkg.
`default_nettype none

module ps2sc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    scan_byte,
    output ps2sc_pkg::job_t    job,
    output logic               job_push
);
    import ps2sc_pkg::*;

    logic [PAUSE_STEP_W-1:0] step_reg, step_next;
    logic                    rel_reg, rel_next;
    logic                    ext_reg, ext_next;

    // Classify the byte and advance the prefix and pause state
    always_comb
    begin
        step_next = step_reg;
        rel_next  = rel_reg;
        ext_next  = ext_reg;
        job_push  = 1'b0;
        job.op    = OP_KEY_MAIN;
        job.code  = scan_byte;
        if (accept)
        begin
            if (step_reg == PAUSE_LAST)
            begin
                step_next = '0;
                job_push  = 1'b1;
                job.op    = (scan_byte == BYTE_PAUSE_B) ? OP_PAUSE : OP_UNKNOWN;
            end
            else if (step_reg != '0)
            begin
                step_next = (scan_byte == PAUSE_EXPECT[step_reg])
                          ? step_reg + 3'd1 : '0;
            end
            else if (scan_byte == BYTE_PAUSE)
            begin
                step_next = 3'd1;
            end
            else if (scan_byte == BYTE_RELEASE)
            begin
                rel_next = 1'b1;
            end
            else if (scan_byte == BYTE_EXT)
            begin
                ext_next = 1'b1;
            end
            else if (rel_reg)
            begin
                rel_next = 1'b0;
                ext_next = 1'b0;
            end
            else if (ext_reg)
            begin
                ext_next = 1'b0;
                job_push = 1'b1;
                job.op   = OP_KEY_EXT;
            end
            else
            begin
                job_push = 1'b1;
                job.op   = OP_KEY_MAIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            rel_reg  <= 1'b0;
            ext_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            rel_reg  <= rel_next;
            ext_reg  <= ext_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ps2sc_queue.sv]
// Short job queue between front and back, built from registers.
// Depends on ps2sc_pkg for the job type.
`default_nettype none

module ps2sc_queue #(
    parameter int DEPTH = ps2sc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  ps2sc_pkg::job_t    push_job,
    output logic               full,
    output logic               pop_valid,
    output ps2sc_pkg::job_t    pop_job,
    input  wire logic          pop
);
    import ps2sc_pkg::*;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

    job_t                slot_reg [DEPTH];
    logic [ADDR_W-1:0]   wr_reg, wr_next;
    logic [ADDR_W-1:0]   rd_reg, rd_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign pop_valid = (cnt_reg != '0);
    assign pop_job   = slot_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == LAST_ADDR) ? '0 : wr_reg + ADDR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == LAST_ADDR) ? '0 : rd_reg + ADDR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + COUNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ps2sc_back.sv]
// Back end: looks up key codes in the valid-code maps and holds the result
// in the output register. Depends on ps2sc_pkg.
`default_nettype none

module ps2sc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  ps2sc_pkg::job_t    job,
    output logic               job_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         event_kind,
    output logic               is_extended,
    output logic [7:0]         key_code
);
    import ps2sc_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic        ext_reg, ext_next;
    logic [7:0]  code_reg;
    logic        load;

    // Load a new result whenever the output register is free or draining
    assign load    = job_valid && (!valid_reg || !out_stall);
    assign job_pop = load;

    always_comb
    begin
        ext_next  = 1'b0;
        kind_next = KIND_UNKNOWN;
        case (job.op)
            OP_KEY_MAIN: kind_next = main_has(job.code) ? KIND_KEY : KIND_UNKNOWN;
            OP_KEY_EXT:
            begin
                ext_next  = 1'b1;
                kind_next = ext_has(job.code) ? KIND_KEY : KIND_UNKNOWN;
            end
            OP_PAUSE:   kind_next = KIND_PAUSE;
            default:    kind_next = KIND_UNKNOWN;
        endcase
        valid_next = load || (valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            ext_reg  <= ext_next;
            code_reg <= job.code;
        end
    end

    assign out_valid   = valid_reg;
    assign event_kind  = kind_reg;
    assign is_extended = ext_reg;
    assign key_code    = code_reg;

endmodule

`default_nettype wire

[rtl/core/ps2_set2_scancode_decoder_unit.sv]
// Top level of the PS/2 scan code set 2 decoder: front, job queue, back.
// Depends on ps2sc_pkg, ps2sc_front, ps2sc_queue and ps2sc_back.
//
//  channel  handshake              payload
//  -------  ---------------------  ----------------------------------
//  in       in_valid / in_stall    scan_byte[7:0]
//  out      out_valid / out_stall  event_kind[1:0], is_extended, key_code[7:0]
//
// One byte per cycle is taken while in_stall is low; jobs wait in the queue.
// The front updates prefix and pause state in the accepting cycle; the back
// does the map lookup into the output register.
// in_stall rises only when the job queue is full (out stalled for a while).
// Reset (rst_n low, asynchronous) clears pause step, prefixes and the queue.
`default_nettype none

module ps2_set2_scancode_decoder_unit #(
    parameter int QUEUE_DEPTH = ps2sc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  scan_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_kind,
    output logic             is_extended,
    output logic [7:0]       key_code
);
    import ps2sc_pkg::*;

    job_t  front_job;
    job_t  back_job;
    logic  front_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  in_accept;

    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    ps2sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .scan_byte (scan_byte),
        .job       (front_job),
        .job_push  (front_push)
    );

    ps2sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_job  (front_job),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_job   (back_job),
        .pop       (q_pop)
    );

    ps2sc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (back_job),
        .job_pop     (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .is_extended (is_extended),
        .key_code    (key_code)
    );

    // Front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(front_push && q_full))
        else $error("job pushed into full queue");

    // Back only pops when a job is present
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("job popped from empty queue");

    // Pause result is never extended and always carries 0x77
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_PAUSE) |-> (!is_extended && key_code == BYTE_PAUSE_B))
        else $error("malformed pause result");

    // Reported kind is always a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == KIND_KEY || event_kind == KIND_PAUSE
                       || event_kind == KIND_UNKNOWN))
        else $error("undefined event kind");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for ps2_set2_scancode_decoder_unit: scan code bytes in, key events out.
// Predicts every event with its own decoder state and scores results in order.
// Depends on ps2sc_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_top;

    import ps2sc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int FILL_ITEMS     = 40;
    localparam int RANDOM_TARGET  = 1560;
    localparam int FINAL_ITEMS    = 150;
    localparam int TAIL_CYCLES    = 8;

    // Valid-code bitmaps indexed by the code itself (bit n set: code n is a key)
    localparam logic [135:0] MAIN_KEYS = {
        8'h08, 8'h7F, 8'hFF, 8'h1A, 8'h40, 8'h2F, 8'h34, 8'h7E, 8'h7E,
        8'h7C, 8'h7E, 8'h7E, 8'h7E, 8'h7C, 8'h76, 8'h7E, 8'hFA
    };
    localparam logic [127:0] EXT_KEYS = {
        8'h34, 8'h37, 8'h1A, 8'h00, 8'h44, 8'h01, 8'h25, 8'h01,
        8'h8D, 8'h95, 8'h89, 8'h8B, 8'h81, 8'h33, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [1:0] kind;
        logic       ext;
        logic [7:0] code;
    } key_event_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] scan_byte;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] event_kind;
    logic       is_extended;
    logic [7:0] key_code;

    // Decoder state as predicted
    logic [2:0] pause_pos;
    logic       release_seen;
    logic       extend_seen;

    key_event_t pending_events[$];
    int         err_count;
    int         sent_items;
    int         hold_req;
    bit         idle_en;

    ps2_set2_scancode_decoder_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .scan_byte   (scan_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .is_extended (is_extended),
        .key_code    (key_code)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Byte at position idx of the pause sequence E1 14 77 E1 F0 14 F0 77
    function automatic logic [7:0] pause_seq_byte(input int idx);
        case (idx)
            0, 3:    return BYTE_PAUSE;
            1, 5:    return BYTE_PAUSE_A;
            2, 7:    return BYTE_PAUSE_B;
            default: return BYTE_RELEASE;
        endcase
    endfunction

    // Advance predicted state by one byte; return 1 when an event results
    function automatic bit decode_scan_byte(input logic [7:0] b, output key_event_t ev);
        ev = '0;
        ev.code = b;
        if (pause_pos == 3'd7)
        begin
            pause_pos = 3'd0;
            ev.kind = (b == BYTE_PAUSE_B) ? KIND_PAUSE : KIND_UNKNOWN;
            return 1'b1;
        end
        if (pause_pos != 3'd0)
        begin
            pause_pos = (b == pause_seq_byte(pause_pos)) ? pause_pos + 3'd1 : 3'd0;
            return 1'b0;
        end
        if (b == BYTE_PAUSE)
        begin
            pause_pos = 3'd1;
            return 1'b0;
        end
        if (b == BYTE_RELEASE)
        begin
            release_seen = 1'b1;
            return 1'b0;
        end
        if (b == BYTE_EXT)
        begin
            extend_seen = 1'b1;
            return 1'b0;
        end
        if (release_seen)
        begin
            release_seen = 1'b0;
            extend_seen = 1'b0;
            return 1'b0;
        end
        if (extend_seen)
        begin
            extend_seen = 1'b0;
            ev.ext = 1'b1;
            ev.kind = (!b[7] && EXT_KEYS[b[6:0]]) ? KIND_KEY : KIND_UNKNOWN;
            return 1'b1;
        end
        ev.kind = (b < 8'd136 && MAIN_KEYS[b]) ? KIND_KEY : KIND_UNKNOWN;
        return 1'b1;
    endfunction

    // Offer one byte, hold it until the transfer, then record what it should produce
    task automatic send_byte(input logic [7:0] b);
        key_event_t ev;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            scan_byte <= 8'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        scan_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (decode_scan_byte(b, ev))
        begin
            pending_events.push_back(ev);
        end
        sent_items++;
    endtask

    // Drop valid and wait until every predicted event has been seen
    task automatic wait_all_events();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_pause(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(pause_seq_byte(i));
        end
    endtask

    // Mostly codes near the map ranges, sometimes any byte
    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 4) != 0)
        begin
            return 8'($urandom_range(0, 8'h87));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            send_byte(pick_code());
        end
        else if (r < 50)
        begin
            send_byte(BYTE_EXT);
            send_byte(pick_code());
        end
        else if (r < 62)
        begin
            send_byte(BYTE_RELEASE);
            send_byte(pick_code());
        end
        else if (r < 67)
        begin
            send_byte(BYTE_EXT);
            send_byte(BYTE_RELEASE);
            send_byte(pick_code());
        end
        else if (r < 77)
        begin
            send_pause(8);
        end
        else if (r < 87)
        begin
            // Break the pause sequence at a random step
            send_pause($urandom_range(1, 7));
            send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_main_codes();
        send_byte(8'h00);
        send_byte(8'h83);
        send_byte(8'h84);
        send_byte(8'hFF);
    endtask

    task automatic test_extended_codes();
        send_byte(BYTE_EXT);
        send_byte(8'h7D);
        send_byte(BYTE_EXT);
        send_byte(8'hFF);
    endtask

    task automatic test_release();
        // Release then extended prefix: both flags stay, the key is swallowed
        send_byte(BYTE_RELEASE);
        send_byte(BYTE_EXT);
        send_byte(8'h75);
    endtask

    task automatic test_pause_sequence();
        send_pause(8);
        // Mismatch in the middle drops the byte
        send_pause(2);
        send_byte(8'h00);
        // Mismatch at the last step reports the byte as unrecognized
        send_pause(7);
        send_byte(8'h1C);
    endtask

    task automatic test_random_mix();
        while (sent_items < RANDOM_TARGET)
        begin
            if (sent_items % 100 == 0)
            begin
                idle_en = ($urandom_range(0, 2) != 0);
            end
            send_random_sequence();
        end
        idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        // Hold the receiver while bytes keep coming so the block stalls its input
        hold_req = LONG_HOLD;
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            send_byte(8'($urandom_range(0, 8'h83)));
        end
        wait_all_events();
    endtask

    task automatic test_no_idle_tail();
        int stop_at;
        idle_en = 1'b0;
        stop_at = sent_items + FINAL_ITEMS;
        while (sent_items < stop_at)
        begin
            send_random_sequence();
        end
        wait_all_events();
    endtask

    // Receiver: stall in random bursts, or for one long stretch on request
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Score each output transfer against the oldest prediction
    always @(posedge clk)
    begin : scoreboard
        key_event_t want;
        key_event_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind: event_kind, ext: is_extended, code: key_code};
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event kind=%0d ext=%0d code=%02h",
                         $time, got.kind, got.ext, got.code);
                err_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (got != want)
                begin
                    $display({"%0t: event mismatch expected kind=%0d ext=%0d code=%02h,",
                              " actual kind=%0d ext=%0d code=%02h"},
                             $time, want.kind, want.ext, want.code,
                             got.kind, got.ext, got.code);
                    err_count++;
                end
            end
        end
    end

    // End the run if no transfer happens on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        scan_byte = 8'h00;
        pause_pos = 3'd0;
        release_seen = 1'b0;
        extend_seen = 1'b0;
        err_count = 0;
        sent_items = 0;
        hold_req = 0;
        idle_en = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_main_codes();
        test_extended_codes();
        test_release();
        test_pause_sequence();
        wait_all_events();
        test_random_mix();
        test_output_backpressure();
        test_no_idle_tail();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_events.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ps2sc_pkg.sv
rtl/core/ps2sc_front.sv
rtl/core/ps2sc_queue.sv
rtl/core/ps2sc_back.sv
rtl/core/ps2_set2_scancode_decoder_unit.sv
dv/tb_top.sv
